>>> hdl/temperature_log_statistics_top_defines.svh
// Assertion helpers shared by the temperature log blocks.
`ifndef TEMPERATURE_LOG_STATISTICS_TOP_DEFINES_SVH
`define TEMPERATURE_LOG_STATISTICS_TOP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the trigger.
`define TLS_ASSERT_IMP(label, clk, rst, trig, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (conseq)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the trigger.
`define TLS_ASSERT_NEXT(label, clk, rst, trig, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (conseq)) \
    else $error(msg);

`endif

>>> hdl/tls_pkg.sv
package tls_pkg;

  localparam int WORD_W            = 32;
  localparam int TEMP_W            = 26;
  localparam int VALUE_W           = 33;
  localparam int KIND_W            = 4;
  localparam int LOG_DEPTH_DEFAULT = 10;

  // Word codes
  localparam logic [WORD_W-1:0] TEMP_MAX = 32'h03FF_FFFF;
  localparam logic [WORD_W-1:0] CMD_AVG  = 32'h0800_0000;
  localparam logic [WORD_W-1:0] CMD_MIN  = 32'h0C00_0000;
  localparam logic [WORD_W-1:0] CMD_MAX  = 32'h1000_0000;
  localparam logic [WORD_W-1:0] CMD_LOG  = 32'h1400_0000;
  localparam logic [WORD_W-1:0] CMD_EXIT = 32'h1800_0000;

  // Twice the hundredths scale, for rounding half away from zero
  localparam logic [7:0] AVG_SCALE = 8'd200;

  typedef enum logic [KIND_W-1:0] {
    KIND_RECEIVED = 4'd0,
    KIND_FULL     = 4'd1,
    KIND_AVERAGE  = 4'd2,
    KIND_MINIMUM  = 4'd3,
    KIND_MAXIMUM  = 4'd4,
    KIND_COUNT    = 4'd5,
    KIND_ENTRY    = 4'd6,
    KIND_EXITING  = 4'd7,
    KIND_ERROR    = 4'd8
  } kind_t;

  typedef enum logic [2:0] {
    WC_TEMP  = 3'd0,
    WC_AVG   = 3'd1,
    WC_MIN   = 3'd2,
    WC_MAX   = 3'd3,
    WC_LOG   = 3'd4,
    WC_EXIT  = 3'd5,
    WC_ERROR = 3'd6
  } word_class_t;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_DIV      = 3'd1,
    ST_LIST_RD  = 3'd2,
    ST_LIST_OUT = 3'd3,
    ST_HALT     = 3'd4
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic  emit;
    kind_t kind;
    logic  last;
    logic  store;
    logic  div_load;
    logic  div_step;
    logic  list_clear;
    logic  list_read;
    logic  list_advance;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    word_class_t word_class;
    logic        full;
    logic        empty;
    logic        div_done;
    logic        list_last;
  } status_t;

endpackage

>>> hdl/tls_ram.sv
module tls_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/tls_ctrl.sv
`include "temperature_log_statistics_top_defines.svh"

module tls_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  tls_pkg::status_t  status,
  output tls_pkg::cmd_t     cmd,
  output logic              busy
);

  import tls_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.kind   = KIND_RECEIVED;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (status.word_class)
            WC_TEMP: begin
              cmd.emit = 1'b1;
              cmd.last = 1'b1;
              if (status.full) begin
                cmd.kind = KIND_FULL;
              end else begin
                cmd.kind  = KIND_RECEIVED;
                cmd.store = 1'b1;
              end
            end
            WC_AVG: begin
              if (status.empty) begin
                cmd.emit = 1'b1;
                cmd.kind = KIND_AVERAGE;
                cmd.last = 1'b1;
              end else begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
              end
            end
            WC_MIN: begin
              cmd.emit = 1'b1;
              cmd.kind = KIND_MINIMUM;
              cmd.last = 1'b1;
            end
            WC_MAX: begin
              cmd.emit = 1'b1;
              cmd.kind = KIND_MAXIMUM;
              cmd.last = 1'b1;
            end
            WC_LOG: begin
              cmd.emit = 1'b1;
              cmd.kind = KIND_COUNT;
              cmd.last = status.empty;
              if (!status.empty) begin
                cmd.list_clear = 1'b1;
                state_next     = ST_LIST_RD;
              end
            end
            WC_EXIT: begin
              cmd.emit   = 1'b1;
              cmd.kind   = KIND_EXITING;
              cmd.last   = 1'b1;
              state_next = ST_HALT;
            end
            default: begin
              cmd.emit = 1'b1;
              cmd.kind = KIND_ERROR;
              cmd.last = 1'b1;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          cmd.emit   = 1'b1;
          cmd.kind   = KIND_AVERAGE;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_LIST_RD: begin
        cmd.list_read = 1'b1;
        state_next    = ST_LIST_OUT;
      end
      ST_LIST_OUT: begin
        cmd.emit         = 1'b1;
        cmd.kind         = KIND_ENTRY;
        cmd.last         = status.list_last;
        cmd.list_advance = 1'b1;
        state_next       = status.list_last ? ST_IDLE : ST_LIST_RD;
      end
      ST_HALT: begin
        // Drop every transaction until reset
        state_next = ST_HALT;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = !((state == ST_IDLE) || (state == ST_HALT));

  `TLS_ASSERT_NEXT(a_last_ends_item, clk, rst, cmd.emit && cmd.last,
    (state == ST_IDLE) || (state == ST_HALT), "final result did not end the item")
  `TLS_ASSERT_NEXT(a_halt_sticks, clk, rst, state == ST_HALT, state == ST_HALT,
    "controller left the halted state")
  `TLS_ASSERT_IMP(a_halt_silent, clk, rst, state == ST_HALT, !cmd.emit,
    "result emitted while halted")

endmodule

>>> hdl/tls_dp.sv
`include "temperature_log_statistics_top_defines.svh"

module tls_dp #(
  parameter int LOG_DEPTH = tls_pkg::LOG_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [tls_pkg::WORD_W-1:0]   word,
  input  tls_pkg::cmd_t                cmd,
  output tls_pkg::status_t             status,
  output logic                         valid,
  output logic [tls_pkg::KIND_W-1:0]   kind,
  output logic [tls_pkg::VALUE_W-1:0]  value,
  output logic                         available,
  output logic                         last
);

  import tls_pkg::*;

  localparam int CNT_W  = $clog2(LOG_DEPTH + 1);
  localparam int IDX_W  = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
  localparam int SUM_W  = TEMP_W + CNT_W;
  localparam int NUM_W  = SUM_W + 8;
  localparam int DEN_W  = CNT_W + 1;
  localparam int STEP_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0]  entry_count;
  logic [SUM_W-1:0]  running_sum;
  logic [TEMP_W-1:0] lowest_seen;
  logic [TEMP_W-1:0] highest_seen;
  logic [TEMP_W-1:0] temp;
  logic [TEMP_W-1:0] log_rdata;
  logic [CNT_W-1:0]  list_idx;

  logic [NUM_W-1:0]  div_quo;
  logic [DEN_W-1:0]  div_rem;
  logic [STEP_W-1:0] div_cnt;
  logic [NUM_W-1:0]  scaled;
  logic [DEN_W-1:0]  den;
  logic [DEN_W:0]    trial;
  logic              trial_ge;

  kind_t              out_kind;
  logic [VALUE_W-1:0] value_next;
  logic               avail_next;

  assign temp = word[TEMP_W-1:0];

  // Classify the incoming word and report the datapath status
  always_comb begin
    status.full      = (entry_count == CNT_W'(LOG_DEPTH));
    status.empty     = (entry_count == '0);
    status.div_done  = (div_cnt == '0);
    status.list_last = ((list_idx + CNT_W'(1)) == entry_count);
    if (word <= TEMP_MAX) begin
      status.word_class = WC_TEMP;
    end else begin
      case (word)
        CMD_AVG:  status.word_class = WC_AVG;
        CMD_MIN:  status.word_class = WC_MIN;
        CMD_MAX:  status.word_class = WC_MAX;
        CMD_LOG:  status.word_class = WC_LOG;
        CMD_EXIT: status.word_class = WC_EXIT;
        default:  status.word_class = WC_ERROR;
      endcase
    end
  end

  // Log store
  tls_ram #(
    .WIDTH  (TEMP_W),
    .DEPTH  (LOG_DEPTH),
    .ADDR_W (IDX_W)
  ) u_log_ram (
    .clk   (clk),
    .we    (cmd.store),
    .waddr (entry_count[IDX_W-1:0]),
    .wdata (temp),
    .re    (cmd.list_read),
    .raddr (list_idx[IDX_W-1:0]),
    .rdata (log_rdata)
  );

  // Update count, sum, minimum and maximum on a stored temperature
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count  <= '0;
      running_sum  <= '0;
      lowest_seen  <= '0;
      highest_seen <= '0;
    end else if (cmd.store) begin
      entry_count <= entry_count + CNT_W'(1);
      running_sum <= running_sum + SUM_W'(temp);
      if (status.empty) begin
        lowest_seen  <= temp;
        highest_seen <= temp;
      end else begin
        if (temp < lowest_seen) begin
          lowest_seen <= temp;
        end
        if (temp > highest_seen) begin
          highest_seen <= temp;
        end
      end
    end
  end

  // Advance the listing index
  always_ff @(posedge clk) begin
    if (cmd.list_clear) begin
      list_idx <= '0;
    end else if (cmd.list_advance) begin
      list_idx <= list_idx + CNT_W'(1);
    end
  end

  // Restoring divider: (200*sum + count) / (2*count), one quotient bit a cycle
  assign scaled   = NUM_W'(running_sum) * NUM_W'(AVG_SCALE) + NUM_W'(entry_count);
  assign den      = {entry_count, 1'b0};
  assign trial    = {div_rem, div_quo[NUM_W-1]};
  assign trial_ge = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_load) begin
      div_cnt <= STEP_W'(NUM_W);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_quo <= scaled;
      div_rem <= '0;
    end else if (cmd.div_step) begin
      div_quo <= {div_quo[NUM_W-2:0], trial_ge};
      div_rem <= trial_ge ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
    end
  end

  // Select the result value
  always_comb begin
    value_next = '0;
    avail_next = 1'b1;
    case (cmd.kind)
      KIND_RECEIVED: value_next = VALUE_W'(temp);
      KIND_AVERAGE: begin
        avail_next = !status.empty;
        value_next = status.empty ? '0 : div_quo[VALUE_W-1:0];
      end
      KIND_MINIMUM: begin
        avail_next = !status.empty;
        value_next = status.empty ? '0 : VALUE_W'(lowest_seen);
      end
      KIND_MAXIMUM: begin
        avail_next = !status.empty;
        value_next = status.empty ? '0 : VALUE_W'(highest_seen);
      end
      KIND_COUNT:   value_next = VALUE_W'(entry_count);
      KIND_ENTRY:   value_next = VALUE_W'(log_rdata);
      default:      value_next = '0;
    endcase
  end

  // Hold each result for one cycle in the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_kind  <= cmd.kind;
      value     <= value_next;
      available <= avail_next;
      last      <= cmd.last;
    end
  end

  assign kind = out_kind;

  `TLS_ASSERT_IMP(a_store_has_room, clk, rst, cmd.store, !status.full,
    "temperature stored into a full log")
  `TLS_ASSERT_IMP(a_min_le_max, clk, rst, !status.empty, lowest_seen <= highest_seen,
    "minimum above maximum")
  `TLS_ASSERT_IMP(a_na_is_zero, clk, rst, valid && !available, value == '0,
    "unavailable result carries a value")
  `TLS_ASSERT_IMP(a_div_step_live, clk, rst, cmd.div_step, div_cnt != '0,
    "divider stepped past its last bit")

endmodule

>>> hdl/temperature_log_statistics_top.sv
// Temperature log with running statistics, driven by 32-bit command words.
// A word is taken when start is high and busy is low; results come out one
// per cycle-wide valid pulse on kind/value/available/last and cannot be held
// off, so the receiver must take every pulse. last marks the final result of
// a word. A temperature, minimum, maximum, exit, error or empty-log command
// keeps busy low. An average runs through the bit-serial divider, one
// quotient bit a cycle. A log listing gives the count and then each entry,
// every entry going through a read state and an output state for the
// registered read of the log memory. After the exit word the block accepts
// and silently drops every word until reset.
module temperature_log_statistics_top #(
  parameter int LOG_DEPTH = tls_pkg::LOG_DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [tls_pkg::WORD_W-1:0]   word,
  output logic                         busy,
  output logic                         valid,
  output logic [tls_pkg::KIND_W-1:0]   kind,
  output logic [tls_pkg::VALUE_W-1:0]  value,
  output logic                         available,
  output logic                         last
);

  import tls_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Sequence each transaction
  tls_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Log storage, statistics, divider and result register
  tls_dp #(
    .LOG_DEPTH (LOG_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .word      (word),
    .cmd       (cmd),
    .status    (status),
    .valid     (valid),
    .kind      (kind),
    .value     (value),
    .available (available),
    .last      (last)
  );

endmodule

>>> test/temperature_log_statistics_top_tb.sv
module temperature_log_statistics_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tls_pkg::*;

  localparam int DEPTH       = LOG_DEPTH_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    kind_t              kind;
    logic [VALUE_W-1:0] value;
    logic               available;
    logic               last;
  } log_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic [WORD_W-1:0]  word = '0;
  logic               busy;
  logic               valid;
  logic [KIND_W-1:0]  kind;
  logic [VALUE_W-1:0] value;
  logic               available;
  logic               last;

  // Shadow copy of the log and its statistics
  logic [TEMP_W-1:0]  shadow_log [DEPTH];
  int                 shadow_count = 0;
  logic [63:0]        shadow_sum = '0;
  logic [TEMP_W-1:0]  shadow_lowest = '0;
  logic [TEMP_W-1:0]  shadow_highest = '0;
  logic               shadow_halted = 1'b0;

  log_result_t        pending_results [$];
  log_result_t        oldest_result;
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  logic               idle_bursts = 1'b1;

  temperature_log_statistics_top #(.LOG_DEPTH(DEPTH)) DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .word      (word),
    .busy      (busy),
    .valid     (valid),
    .kind      (kind),
    .value     (value),
    .available (available),
    .last      (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Advance the shadow log by one word and queue the results it causes
  task automatic log_model_apply(input logic [WORD_W-1:0] w);
    log_result_t r;
    logic [63:0] scaled_mean;
    if (shadow_halted) return;
    r.kind      = KIND_ERROR;
    r.value     = '0;
    r.available = 1'b1;
    r.last      = 1'b1;
    if (w <= TEMP_MAX) begin
      if (shadow_count < DEPTH) begin
        shadow_log[shadow_count] = w[TEMP_W-1:0];
        shadow_count++;
        shadow_sum += 64'(w);
        if (shadow_count == 1) begin
          shadow_lowest  = w[TEMP_W-1:0];
          shadow_highest = w[TEMP_W-1:0];
        end else begin
          if (w[TEMP_W-1:0] > shadow_highest) shadow_highest = w[TEMP_W-1:0];
          if (w[TEMP_W-1:0] < shadow_lowest) shadow_lowest = w[TEMP_W-1:0];
        end
        r.kind  = KIND_RECEIVED;
        r.value = VALUE_W'(w);
      end else begin
        r.kind = KIND_FULL;
      end
    end else begin
      case (w)
        CMD_AVG: begin
          r.kind = KIND_AVERAGE;
          if (shadow_count == 0) begin
            r.available = 1'b0;
          end else begin
            // round half away from zero in hundredths
            scaled_mean = (64'd200 * shadow_sum + 64'(shadow_count)) /
                          (64'd2 * 64'(shadow_count));
            r.value = scaled_mean[VALUE_W-1:0];
          end
        end
        CMD_MIN: begin
          r.kind      = KIND_MINIMUM;
          r.value     = (shadow_count == 0) ? '0 : VALUE_W'(shadow_lowest);
          r.available = (shadow_count != 0);
        end
        CMD_MAX: begin
          r.kind      = KIND_MAXIMUM;
          r.value     = (shadow_count == 0) ? '0 : VALUE_W'(shadow_highest);
          r.available = (shadow_count != 0);
        end
        CMD_LOG: begin
          // count first, then each entry; the final one goes out below
          r.kind  = KIND_COUNT;
          r.value = VALUE_W'(shadow_count);
          r.last  = (shadow_count == 0);
          for (int i = 0; i < shadow_count; i++) begin
            pending_results.push_back(r);
            r.kind  = KIND_ENTRY;
            r.value = VALUE_W'(shadow_log[i]);
            r.last  = (i == shadow_count - 1);
          end
        end
        CMD_EXIT: begin
          r.kind        = KIND_EXITING;
          shadow_halted = 1'b1;
        end
        default: r.kind = KIND_ERROR;
      endcase
    end
    pending_results.push_back(r);
  endtask

  // Send one word as a transaction, with an optional idle burst ahead of it
  task automatic send_word(input logic [WORD_W-1:0] w);
    if (idle_bursts && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start <= 1'b1;
    word  <= w;
    do @(posedge clk); while (busy);
    log_model_apply(w);
  endtask

  // Hold the sender off until every queued result has come back
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_log();
    send_word(CMD_AVG);
    send_word(CMD_MIN);
    send_word(CMD_MAX);
    send_word(CMD_LOG);
  endtask

  // Words just outside the temperature range and near the command codes
  task automatic test_bad_words();
    send_word(32'h0400_0000);
    send_word(32'h07FF_FFFF);
    send_word(CMD_AVG + 32'd1);
    send_word(CMD_MIN - 32'd1);
    send_word(CMD_EXIT + 32'h0400_0000);
    send_word(32'h8000_0000);
    send_word(32'hFFFF_FFFF);
  endtask

  task automatic test_temperature_extremes();
    send_word(TEMP_MAX);
    send_word(32'd0);
    send_word(CMD_AVG);
    send_word(CMD_MIN);
    send_word(CMD_MAX);
    send_word(CMD_LOG);
  endtask

  task automatic test_drain_pause();
    send_word(CMD_LOG);
    send_word(CMD_AVG);
    drain_results();
    send_word(CMD_LOG);
    send_word(CMD_AVG);
  endtask

  // Mix temperatures, queries, listings and stray words
  task automatic test_random_traffic(input int n_words, input logic with_idle);
    logic [WORD_W-1:0] w;
    int                pick;
    idle_bursts = with_idle;
    repeat (n_words) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        case ($urandom_range(0, 3))
          0:       w = '0;
          1:       w = TEMP_MAX;
          2:       w = $urandom_range(0, 255);
          default: w = $urandom_range(0, TEMP_MAX);
        endcase
      end else if (pick < 50) begin
        w = CMD_AVG;
      end else if (pick < 58) begin
        w = CMD_MIN;
      end else if (pick < 66) begin
        w = CMD_MAX;
      end else if (pick < 80) begin
        w = CMD_LOG;
      end else begin
        w = $urandom();
        // keep exit out of the random stream
        if (w == CMD_EXIT) w = w ^ 32'd1;
      end
      send_word(w);
    end
  endtask

  // After exit every word is dropped without a result
  task automatic test_exit_halt();
    send_word(CMD_EXIT);
    send_word(CMD_AVG);
    send_word(CMD_LOG);
    send_word($urandom_range(0, TEMP_MAX));
    send_word($urandom());
  endtask

  // Check each result against the oldest queued one
  always @(posedge clk) begin
    if (!rst && valid) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: kind %0d value %0d available %0b last %0b",
                   kind, value, available, last);
      end else begin
        oldest_result = pending_results.pop_front();
        if (kind !== oldest_result.kind || value !== oldest_result.value ||
            available !== oldest_result.available || last !== oldest_result.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result mismatch: expected kind %0d value %0d available %0b last %0b",
                     oldest_result.kind, oldest_result.value, oldest_result.available,
                     oldest_result.last);
            $display("                 got kind %0d value %0d available %0b last %0b",
                     kind, value, available, last);
          end
        end
      end
    end
  end

  // Drop the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("temperature_log_statistics_top: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_log();
    test_bad_words();
    test_temperature_extremes();
    test_random_traffic(170, 1'b1);
    test_drain_pause();
    test_random_traffic(50, 1'b0);
    test_exit_halt();
    drain_results();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("temperature_log_statistics_top: match");
    end else begin
      $display("temperature_log_statistics_top: mismatch");
    end
    $finish;
  end

endmodule
